// File: design/tag_position_smoother_polar_unit_assert.svh
// Assertion macros for the tag position smoother.
`ifndef TAG_POSITION_SMOOTHER_POLAR_UNIT_ASSERT_SVH
`define TAG_POSITION_SMOOTHER_POLAR_UNIT_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define TPS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/tps_pkg.sv
// ----------------------------------------------------------------------------
// tps_pkg
// Shared widths, constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package tps_pkg;

    localparam int WINDOW_DEF   = 12;
    localparam int CORDIC_STEPS = 21;
    localparam int XW           = 20;
    localparam int YW           = 21;
    localparam int GAP_W        = 16;
    localparam int FAR_W        = 20;
    localparam int BEAR_W       = 16;
    localparam int CW           = 32;  // CORDIC datapath
    localparam int ZW           = 26;  // angle in pi/2^23
    localparam logic [15:0] GAP_RESET = 16'd1800;
    localparam logic [19:0] FAR_RESET = 20'd12000;

    localparam logic CFG_GAP = 1'b0;
    localparam logic CFG_FAR = 1'b1;

    function automatic logic [ZW-1:0] atan_lut(input logic [4:0] i);
        logic [ZW-1:0] r;
        begin
            case (i)
                5'd0:  r = 26'd2097152;
                5'd1:  r = 26'd1238021;
                5'd2:  r = 26'd654136;
                5'd3:  r = 26'd332050;
                5'd4:  r = 26'd166669;
                5'd5:  r = 26'd83416;
                5'd6:  r = 26'd41718;
                5'd7:  r = 26'd20860;
                5'd8:  r = 26'd10430;
                5'd9:  r = 26'd5215;
                5'd10: r = 26'd2608;
                5'd11: r = 26'd1304;
                5'd12: r = 26'd652;
                5'd13: r = 26'd326;
                5'd14: r = 26'd163;
                5'd15: r = 26'd81;
                5'd16: r = 26'd41;
                5'd17: r = 26'd20;
                5'd18: r = 26'd10;
                5'd19: r = 26'd5;
                5'd20: r = 26'd3;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

// File: design/tag_position_smoother_polar_unit.sv
// ----------------------------------------------------------------------------
// tag_position_smoother_polar_unit
// Sliding-window average of tag position, then distance and bearing.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready take one (x, y) word. y is offset by half the antenna gap,
//   both go into WINDOW-deep windows and the running sums are divided by the
//   fill count. Distance (rounded sqrt, clamped to far_reg) and bearing
//   (21-step vectoring CORDIC) follow, on m_valid/m_ready.
//   Steps in order: window update, rounding divide of x then y, square x
//   and y and sum them, rounded sqrt, CORDIC setup, CORDIC steps. One word
//   at a time: s_ready is low from accept until the result leaves the output
//   register. The divider retires one quotient bit per cycle, the sqrt one
//   root bit per cycle and CORDIC one step per cycle.
//   A stalled m_ready holds the result; no further word is taken.
//   Reset clears sums, fill count, write slot and restores register defaults.
//   Config writes (cfg_we, cfg_index, cfg_wdata) take effect at once; write
//   only while no word is in flight.
// ----------------------------------------------------------------------------
`include "tag_position_smoother_polar_unit_assert.svh"

module tag_position_smoother_polar_unit
    import tps_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic                    cfg_index,
    input  logic [FAR_W-1:0]        cfg_wdata,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [XW-1:0]    s_x_mm,
    input  logic signed [XW-1:0]    s_y_mm,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [XW-1:0]    m_avg_x_mm,
    output logic signed [YW-1:0]    m_avg_y_mm,
    output logic [FAR_W-1:0]        m_distance_mm,
    output logic signed [BEAR_W-1:0] m_bearing,
    output logic                    m_distance_clamped
);

    localparam int IW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNW = $clog2(WINDOW + 1);
    localparam int SXW = XW + $clog2(WINDOW + 1);
    localparam int SYW = YW + $clog2(WINDOW + 1);
    localparam int DQW = SYW;            // divider magnitude width
    localparam int DCW = $clog2(DQW + 1);
    localparam int SQW = 2 * YW;         // sum of squares fits 42 bits
    localparam int RW  = YW + 1;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_UPD  = 9'b000000010,
        S_DIV  = 9'b000000100,
        S_SQ   = 9'b000001000,
        S_SQA  = 9'b000010000,
        S_SQRT = 9'b000100000,
        S_CPRE = 9'b001000000,
        S_CORD = 9'b010000000,
        S_OUT  = 9'b100000000
    } state_t;

    state_t state_reg;

    logic [GAP_W-1:0] gap_reg;
    logic [FAR_W-1:0] far_reg;

    logic signed [XW-1:0] xwin [WINDOW];
    logic signed [YW-1:0] ywin [WINDOW];
    logic signed [SXW-1:0] xsum_reg;
    logic signed [SYW-1:0] ysum_reg;
    logic [CNW-1:0] fill_reg;
    logic [IW-1:0]  slot_reg;
    logic signed [XW-1:0] xin_reg;
    logic signed [YW-1:0] yin_reg;
    logic signed [XW-1:0] xold_reg;
    logic signed [YW-1:0] yold_reg;

    // shared restoring divider
    logic            dsel_reg;   // 0: x, 1: y
    logic [DQW-1:0]  dnum_reg;
    logic [CNW-1:0]  drem_reg;
    logic [DCW-1:0]  dcnt_reg;
    logic            dneg_reg;
    logic signed [XW-1:0] ax_reg;
    logic signed [YW-1:0] ay_reg;

    logic [SQW-1:0] sq_reg;
    logic [SQW-1:0] prod_reg;
    logic [SQW-1:0] rem_reg;
    logic [RW-1:0]  root_reg;
    logic [5:0]     scnt_reg;

    logic signed [CW-1:0] cx_reg, cy_reg;
    logic signed [ZW-1:0] cz_reg;
    logic [4:0] ccnt_reg;
    logic       axis_reg;        // bearing taken from the axis cases
    logic signed [BEAR_W-1:0] axis_bear_reg;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);

    // divider step
    logic [CNW:0] dtrial;
    logic [CNW:0] dshift;
    assign dshift = {drem_reg, dnum_reg[DQW-1]};
    assign dtrial = dshift - {1'b0, fill_reg};

    // sqrt step: two bits per iteration
    logic [SQW-1:0] rshift;
    logic [SQW-1:0] strial;
    logic [SQW-1:0] sqshift;
    assign rshift  = {rem_reg[SQW-3:0], sq_reg[SQW-1:SQW-2]};
    assign strial  = {{(SQW-RW-2){1'b0}}, root_reg, 2'b01};
    assign sqshift = {sq_reg[SQW-3:0], 2'b00};

    // CORDIC step
    logic signed [CW-1:0] cdx, cdy;
    assign cdx = cy_reg >>> ccnt_reg;
    assign cdy = cx_reg >>> ccnt_reg;

    logic signed [SYW-1:0] ysel;
    logic signed [SYW-1:0] ydiv_src;
    logic signed [SYW-1:0] mag_src;
    assign ysel     = dsel_reg ? ysum_reg : SYW'(xsum_reg);
    assign ydiv_src = ysel;
    assign mag_src  = ydiv_src[SYW-1] ? -ydiv_src : ydiv_src;

    logic [DQW-1:0] qround;
    assign qround = dnum_reg;

    logic signed [YW-1:0]  sq_op;
    logic signed [SQW-1:0] sq_prod;
    assign sq_op   = dsel_reg ? ay_reg : YW'(ax_reg);
    assign sq_prod = $signed(sq_op) * $signed(sq_op);

    // angle + half LSB; bits above 8 give the floor-shifted bearing
    logic signed [ZW-1:0] zr;
    assign zr = cz_reg + ZW'(128);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            gap_reg   <= GAP_RESET;
            far_reg   <= FAR_RESET;
            xsum_reg  <= '0;
            ysum_reg  <= '0;
            fill_reg  <= '0;
            slot_reg  <= '0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_GAP) gap_reg <= cfg_wdata[GAP_W-1:0];
                else                      far_reg <= cfg_wdata;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        xin_reg  <= s_x_mm;
                        yin_reg  <= YW'(s_y_mm) - YW'({1'b0, gap_reg[GAP_W-1:1]});
                        xold_reg <= xwin[slot_reg];
                        yold_reg <= ywin[slot_reg];
                        state_reg <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (fill_reg == CNW'(WINDOW)) begin
                        xsum_reg <= xsum_reg - SXW'(xold_reg) + SXW'(xin_reg);
                        ysum_reg <= ysum_reg - SYW'(yold_reg) + SYW'(yin_reg);
                    end else begin
                        fill_reg <= fill_reg + 1'b1;
                        xsum_reg <= xsum_reg + SXW'(xin_reg);
                        ysum_reg <= ysum_reg + SYW'(yin_reg);
                    end
                    xwin[slot_reg] <= xin_reg;
                    ywin[slot_reg] <= yin_reg;
                    slot_reg <= (slot_reg == IW'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
                    dsel_reg <= 1'b0;
                    dcnt_reg <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (dcnt_reg == '0) begin
                        // load |sum| + n/2
                        dnum_reg <= DQW'(mag_src) + DQW'(fill_reg >> 1);
                        dneg_reg <= ydiv_src[SYW-1];
                        drem_reg <= '0;
                        dcnt_reg <= dcnt_reg + 1'b1;
                    end else if (dcnt_reg <= DCW'(DQW)) begin
                        if (!dtrial[CNW]) begin
                            drem_reg <= dtrial[CNW-1:0];
                            dnum_reg <= {dnum_reg[DQW-2:0], 1'b1};
                        end else begin
                            drem_reg <= dshift[CNW-1:0];
                            dnum_reg <= {dnum_reg[DQW-2:0], 1'b0};
                        end
                        dcnt_reg <= dcnt_reg + 1'b1;
                    end else begin
                        if (!dsel_reg) begin
                            ax_reg <= dneg_reg ? -XW'(qround) : XW'(qround);
                            dsel_reg <= 1'b1;
                            dcnt_reg <= '0;
                        end else begin
                            ay_reg <= dneg_reg ? -YW'(qround) : YW'(qround);
                            state_reg <= S_SQ;
                            dsel_reg <= 1'b0;
                        end
                    end
                end
                S_SQ: begin
                    prod_reg <= sq_prod;
                    state_reg <= S_SQA;
                end
                S_SQA: begin
                    if (!dsel_reg) begin
                        sq_reg   <= prod_reg;
                        dsel_reg <= 1'b1;
                        state_reg <= S_SQ;
                    end else begin
                        sq_reg   <= sq_reg + prod_reg;
                        rem_reg  <= '0;
                        root_reg <= '0;
                        scnt_reg <= '0;
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (scnt_reg < 6'(SQW / 2)) begin
                        if (rshift >= strial) begin
                            rem_reg  <= rshift - strial;
                            root_reg <= {root_reg[RW-2:0], 1'b1};
                        end else begin
                            rem_reg  <= rshift;
                            root_reg <= {root_reg[RW-2:0], 1'b0};
                        end
                        sq_reg   <= sqshift;
                        scnt_reg <= scnt_reg + 1'b1;
                    end else begin
                        // round: remainder > root
                        if (rem_reg > SQW'(root_reg)) root_reg <= root_reg + 1'b1;
                        state_reg <= S_CPRE;
                    end
                end
                S_CPRE: begin
                    axis_reg <= 1'b0;
                    ccnt_reg <= '0;
                    if (ay_reg == '0) begin
                        axis_reg <= 1'b1;
                        axis_bear_reg <= ax_reg[XW-1] ? 16'sh8000 : 16'sd0;
                    end else if (ax_reg == '0) begin
                        axis_reg <= 1'b1;
                        axis_bear_reg <= ay_reg[YW-1] ? -16'sd16384 : 16'sd16384;
                    end
                    if (ax_reg[XW-1]) begin
                        cz_reg <= ay_reg[YW-1] ? -26'sd8388608 : 26'sd8388608;
                        cx_reg <= CW'(-(CW'(ax_reg))) <<< 8;
                        cy_reg <= CW'(-(CW'(ay_reg))) <<< 8;
                    end else begin
                        cz_reg <= '0;
                        cx_reg <= CW'(ax_reg) <<< 8;
                        cy_reg <= CW'(ay_reg) <<< 8;
                    end
                    state_reg <= S_CORD;
                end
                S_CORD: begin
                    if (!cy_reg[CW-1]) begin
                        cx_reg <= cx_reg + cdx;
                        cy_reg <= cy_reg - cdy;
                        cz_reg <= cz_reg + $signed(atan_lut(ccnt_reg));
                    end else begin
                        cx_reg <= cx_reg - cdx;
                        cy_reg <= cy_reg + cdy;
                        cz_reg <= cz_reg - $signed(atan_lut(ccnt_reg));
                    end
                    if (ccnt_reg == 5'(CORDIC_STEPS - 1)) begin
                        state_reg <= S_OUT;
                    end
                    ccnt_reg <= ccnt_reg + 1'b1;
                end
                S_OUT: begin
                    if (m_ready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    logic root_over;
    assign root_over = (root_reg > RW'(far_reg));

    assign m_avg_x_mm         = ax_reg;
    assign m_avg_y_mm         = ay_reg;
    assign m_distance_clamped = root_over;
    assign m_distance_mm      = root_over ? far_reg : root_reg[FAR_W-1:0];
    assign m_bearing          = axis_reg ? axis_bear_reg : zr[BEAR_W+7:8];

    `TPS_ASSERT_IMPL(a_one_side, aclk, aresetn, 1'b1, !(s_ready && m_valid),
        "input and output both open")
    `TPS_ASSERT_NEXT(a_hold_out, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_distance_mm), "result dropped while stalled")
    `TPS_ASSERT_IMPL(a_fill_max, aclk, aresetn, 1'b1, fill_reg <= CNW'(WINDOW),
        "fill count beyond window")

endmodule

// File: tb/tag_position_smoother_polar_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tag_position_smoother_polar_unit_tb
// Drives tag position words through the smoother and checks each averaged
// point, distance, clamp flag and bearing against a local model of the
// window sums, rounding divide, rounded square root and vectoring CORDIC.
// ----------------------------------------------------------------------------
module tag_position_smoother_polar_unit_tb;
    import tps_pkg::*;

    localparam int WIN       = 12;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 740;
    localparam int QD        = 1024;

    typedef struct packed {
        logic signed [XW-1:0]     ax;
        logic signed [YW-1:0]     ay;
        logic [FAR_W-1:0]         range_mm;
        logic signed [BEAR_W-1:0] bear;
        logic                     clamp;
    } polar_t;

    // directed row: expected given only when known is set
    typedef struct {
        logic        do_cfg;
        logic        cfg_idx;
        logic [19:0] cfg_val;
        logic [19:0] x;
        logic [19:0] y;
        logic        known;
        polar_t      res;
    } row_t;

    logic aclk, aresetn;
    logic cfg_we, cfg_index;
    logic [FAR_W-1:0] cfg_wdata;
    logic s_valid, s_ready, m_valid, m_ready;
    logic signed [XW-1:0] s_x_mm, s_y_mm;
    logic signed [XW-1:0] m_avg_x_mm;
    logic signed [YW-1:0] m_avg_y_mm;
    logic [FAR_W-1:0] m_distance_mm;
    logic signed [BEAR_W-1:0] m_bearing;
    logic m_distance_clamped;

    tag_position_smoother_polar_unit uut (.*);

    // model state
    longint gap_mm, far_mm;
    longint xwin[WIN], ywin[WIN];
    longint xsum, ysum;
    int fill, slot;

    // pending words, in send order
    polar_t exp_store[QD];
    polar_t row_store[QD];
    bit     known_store[QD];
    int     wr_cnt, rd_cnt;
    int     errors, mism;
    int     idle_in, stall_out;
    int     wdog;
    bit     timed_out;

    function automatic longint asr64(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_div(longint s, int n);
        longint mag, q;
        mag = (s < 0) ? -s : s;
        q = (mag + n / 2) / n;
        return (s < 0) ? -q : q;
    endfunction

    function automatic longint round_sqrt(longint v);
        longint r, b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        if (v > r) r++;
        return r;
    endfunction

    function automatic longint cordic_bearing(longint x, longint y);
        longint z, dx, dy;
        longint tab[21] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718,
            20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3};
        z = 0;
        if (y == 0) return (x < 0) ? 32768 : 0;
        if (x == 0) return (y > 0) ? 16384 : -16384;
        if (x < 0) begin
            z = (y > 0) ? (64'sd1 <<< 23) : -(64'sd1 <<< 23);
            x = -x;
            y = -y;
        end
        x = x * 256;
        y = y * 256;
        for (int i = 0; i < 21; i++) begin
            dx = asr64(y, i);
            dy = asr64(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; z += tab[i];
            end else begin
                x -= dx; y += dy; z -= tab[i];
            end
        end
        return asr64(z + 128, 8);
    endfunction

    function automatic polar_t smooth_sample(logic [19:0] xr, logic [19:0] yr);
        longint x, y, ax, ay, d, b;
        polar_t r;
        x = longint'($signed(xr));
        y = longint'($signed(yr)) - (gap_mm >> 1);
        if (fill < WIN) fill++;
        else begin
            xsum -= xwin[slot];
            ysum -= ywin[slot];
        end
        xsum += x;
        ysum += y;
        xwin[slot] = x;
        ywin[slot] = y;
        slot = (slot + 1 >= WIN) ? 0 : slot + 1;
        ax = round_div(xsum, fill);
        ay = round_div(ysum, fill);
        d = round_sqrt(ax * ax + ay * ay);
        r.clamp = 1'b0;
        if (d > far_mm) begin
            d = far_mm;
            r.clamp = 1'b1;
        end
        b = cordic_bearing(ax, ay);
        r.ax = ax[XW-1:0];
        r.ay = ay[YW-1:0];
        r.range_mm = d[FAR_W-1:0];
        r.bear = b[BEAR_W-1:0];
        return r;
    endfunction

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result checker and stall generator
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            polar_t got, exp_r, row_r;
            got = '{m_avg_x_mm, m_avg_y_mm, m_distance_mm, m_bearing,
                    m_distance_clamped};
            if (wr_cnt == rd_cnt) begin
                errors++;
                if (mism++ < 10) $display("unexpected result word %p", got);
            end else begin
                exp_r = exp_store[rd_cnt % QD];
                row_r = row_store[rd_cnt % QD];
                if (known_store[rd_cnt % QD] && row_r !== exp_r) begin
                    errors++;
                    if (mism++ < 10)
                        $display("table row disagrees with model: exp %p row %p",
                            exp_r, row_r);
                end
                rd_cnt++;
                if (got.ax !== exp_r.ax || got.ay !== exp_r.ay ||
                    got.range_mm !== exp_r.range_mm || got.bear !== exp_r.bear ||
                    got.clamp !== exp_r.clamp) begin
                    errors++;
                    if (mism++ < 10)
                        $display("mismatch: exp ax=%0d ay=%0d d=%0d b=%0d c=%0b",
                            exp_r.ax, exp_r.ay, exp_r.range_mm, exp_r.bear, exp_r.clamp,
                            " got ax=%0d ay=%0d d=%0d b=%0d c=%0b",
                            got.ax, got.ay, got.range_mm, got.bear, got.clamp);
                end
            end
        end
        m_ready <= ($urandom_range(99) >= stall_out);
    end

    // watchdog on accepted words
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) wdog <= 0;
        else wdog <= wdog + 1;
        if (wdog >= WDOG_MAX) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic idx, logic [19:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_GAP) gap_mm = val[15:0];
        else far_mm = val;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (wr_cnt != rd_cnt) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic send_word(logic [19:0] x, logic [19:0] y, bit known, polar_t k);
        while ($urandom_range(99) < idle_in) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_x_mm  <= x;
        s_y_mm  <= y;
        exp_store[wr_cnt % QD]   = smooth_sample(x, y);
        known_store[wr_cnt % QD] = known;
        row_store[wr_cnt % QD]   = k;
        wr_cnt++;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic logic [19:0] rand_coord(int mode);
        case (mode)
            0: return 20'($urandom);
            1: return 20'($signed($urandom_range(16000)) - 8000);
            2: return 20'($signed($urandom_range(200)) - 100);
            default: return $urandom_range(1) ? 20'h7FFFF : 20'h80000;
        endcase
    endfunction

    row_t dir_tab[23] = '{
        // gap 1800: y=900 cancels the offset, x=1000 on axis
        '{0, 0, 0, 20'd1000, 20'd900, 1, '{20'sd1000, 21'sd0, 20'd1000, 16'sd0, 1'b0}},
        '{0, 0, 0, 20'd1000, 20'd900, 1, '{20'sd1000, 21'sd0, 20'd1000, 16'sd0, 1'b0}},
        '{1, CFG_GAP, 20'd0, 20'd0, 20'd0, 0, '{default: '0}},
        '{0, 0, 0, 20'h7FFFF, 20'h7FFFF, 0, '{default: '0}},
        '{0, 0, 0, 20'h80000, 20'h80000, 0, '{default: '0}},
        '{1, CFG_FAR, 20'hFFFFF, 20'd0, 20'd0, 0, '{default: '0}},
        '{0, 0, 0, 20'h80000, 20'h7FFFF, 0, '{default: '0}},
        '{0, 0, 0, 20'h7FFFF, 20'h80000, 0, '{default: '0}},
        '{1, CFG_GAP, 20'd65535, 20'd0, 20'd0, 0, '{default: '0}},
        '{0, 0, 0, 20'd0, 20'd0, 0, '{default: '0}},
        '{0, 0, 0, 20'd3, 20'd7, 0, '{default: '0}},
        '{1, CFG_GAP, 20'd1, 20'd0, 20'd0, 0, '{default: '0}},
        '{0, 0, 0, 20'hFFFFF, 20'd1, 0, '{default: '0}},
        '{0, 0, 0, 20'd2, 20'hFFFFE, 0, '{default: '0}},
        '{1, CFG_FAR, 20'd0, 20'd0, 20'd0, 0, '{default: '0}},
        '{0, 0, 0, 20'd5, 20'd5, 0, '{default: '0}},
        '{0, 0, 0, 20'h80000, 20'd0, 0, '{default: '0}},
        '{1, CFG_FAR, 20'd12000, 20'd0, 20'd0, 0, '{default: '0}},
        '{0, 0, 0, 20'd40000, 20'd0, 0, '{default: '0}},
        '{0, 0, 0, 20'd0, 20'd40000, 0, '{default: '0}},
        '{0, 0, 0, 20'd0, 20'hF0000, 0, '{default: '0}},
        '{0, 0, 0, 20'hFF000, 20'd10, 0, '{default: '0}},
        '{0, 0, 0, 20'hFF000, 20'hFFFF0, 0, '{default: '0}}
    };

    initial begin
        int phase, mode, n;
        aresetn = 1'b0; cfg_we = 1'b0; cfg_index = 1'b0; cfg_wdata = '0;
        s_valid = 1'b0; s_x_mm = '0; s_y_mm = '0; m_ready = 1'b0;
        idle_in = 0; stall_out = 0; errors = 0; mism = 0; wdog = 0;
        wr_cnt = 0; rd_cnt = 0;
        gap_mm = GAP_RESET; far_mm = FAR_RESET;
        xsum = 0; ysum = 0; fill = 0; slot = 0;
        foreach (xwin[i]) begin xwin[i] = 0; ywin[i] = 0; end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].do_cfg) begin
                drain();
                write_reg(dir_tab[i].cfg_idx, dir_tab[i].cfg_val);
            end else begin
                send_word(dir_tab[i].x, dir_tab[i].y, dir_tab[i].known, dir_tab[i].res);
            end
        end

        for (n = 0; n < N_RANDOM; n++) begin
            if (n % 60 == 0) begin
                phase = (n / 60) % 4;
                idle_in   = (phase == 1 || phase == 3) ? ((phase == 3) ? 36 : 47) : 0;
                stall_out = (phase == 2 || phase == 3) ? ((phase == 3) ? 36 : 47) : 0;
                drain();
                write_reg(CFG_GAP, $urandom_range(3) == 0 ? 20'($urandom_range(1) * 65535)
                                                          : 20'($urandom_range(4000)));
                write_reg(CFG_FAR, $urandom_range(3) == 0 ? 20'($urandom)
                                                          : 20'($urandom_range(20000)));
                mode = $urandom_range(3);
            end
            if ($urandom_range(9) == 0) mode = $urandom_range(3);
            send_word(rand_coord(mode), rand_coord(mode), 0, '{default: '0});
        end
        s_valid <= 1'b0;

        timed_out = 0;
        n = 0;
        while (wr_cnt != rd_cnt && n < 100000) begin
            @(posedge aclk);
            n++;
        end
        if (n >= 100000) timed_out = 1;
        repeat (150) @(posedge aclk);
        if (errors == 0 && !timed_out && wr_cnt == rd_cnt) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

// File: filelist.f
+incdir+design
design/tps_pkg.sv
design/tag_position_smoother_polar_unit.sv
tb/tag_position_smoother_polar_unit_tb.sv
